/* rtl/afc_pkg.sv */
`timescale 1ns / 1ps
// shared types and codes for the fade transport controller
// no dependencies; imported by the top module only

package afc_pkg;

   localparam int KIND_W   = 1;
   localparam int MODE_W   = 3;
   localparam int TICKS_W  = 24;
   localparam int LVL_W    = 17;
   localparam int GAIN_W   = 17;
   localparam int ACT_W    = 2;
   localparam int PHASE_W  = 2;

   localparam logic [KIND_W-1:0] KIND_TICK = 1'b0;
   localparam logic [KIND_W-1:0] KIND_CMD  = 1'b1;

   localparam logic [MODE_W-1:0] MODE_PLAY_NOW   = 3'd0;
   localparam logic [MODE_W-1:0] MODE_PLAY_FADE  = 3'd1;
   localparam logic [MODE_W-1:0] MODE_PAUSE_NOW  = 3'd2;
   localparam logic [MODE_W-1:0] MODE_PAUSE_FADE = 3'd3;
   localparam logic [MODE_W-1:0] MODE_STOP_NOW   = 3'd4;
   localparam logic [MODE_W-1:0] MODE_STOP_FADE  = 3'd5;

   typedef enum logic [PHASE_W-1:0] {
      PH_READY = 2'd0,
      PH_WAIT  = 2'd1,
      PH_DONE  = 2'd2,
      PH_EOS   = 2'd3
   } phase_type;

   typedef enum logic [ACT_W-1:0] {
      ACT_NONE  = 2'd0,
      ACT_PLAY  = 2'd1,
      ACT_PAUSE = 2'd2,
      ACT_STOP  = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP,
      ST_LVL,
      ST_DIV,
      ST_APPLY,
      ST_SQR,
      ST_OUT
   } state_type;

endpackage

/* rtl/audio_fade_transport_controller_unit.sv */
`timescale 1ns / 1ps
// fade transport controller top: command decode, timer, voice phase sequencer
// uses afc_pkg, afc_divider and afc_squarer
//
//   port group  direction  handshake               word
//   req_        in         req_valid / req_stall   tick or command
//   rsp_        out        rsp_valid / rsp_stall   level, gain, action, phase
//
// a word holds the input through the prep and out states when ignored, and through prep,
// lvl, apply and out otherwise, plus the serial ramp divider on a running fade,
// plus the serial squarer when the level changes below full
// reset is synchronous; after it the block is in stop, done, level zero
// a new word is taken while a result waits; it then holds before its result

module audio_fade_transport_controller_unit #(
   parameter int TIME_BITS  = 24,
   parameter int LEVEL_BITS = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [afc_pkg::KIND_W-1:0]  req_kind,
   input  logic [afc_pkg::MODE_W-1:0]  req_mode_request,
   input  logic [afc_pkg::TICKS_W-1:0] req_fade_ticks,
   input  logic                        req_stream_ended,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [afc_pkg::LVL_W-1:0]   rsp_fade_level,
   output logic [afc_pkg::GAIN_W-1:0]  rsp_gain,
   output logic                        rsp_gain_update,
   output logic [afc_pkg::ACT_W-1:0]   rsp_transport_action,
   output logic                        rsp_seek_to_start,
   output logic                        rsp_ignored,
   output logic [afc_pkg::PHASE_W-1:0] rsp_voice_phase
);

   import afc_pkg::*;

   localparam int TW = (TIME_BITS > TICKS_W) ? TIME_BITS : TICKS_W;
   localparam logic [TIME_BITS-1:0]  TIME_MAX = '1;
   localparam logic [LEVEL_BITS:0]   LVL_ONE  = {1'b1, {LEVEL_BITS{1'b0}}};

   state_type             state_ff, state_in;
   logic [MODE_W-1:0]     mode_ff, mode_in;
   phase_type             phase_ff, phase_in;
   logic [TIME_BITS-1:0]  fade_len_ff, fade_len_in;
   logic [TIME_BITS-1:0]  elapsed_ff, elapsed_in;
   logic                  running_ff, running_in;
   logic [LEVEL_BITS:0]   level_ff, level_in;
   logic [LEVEL_BITS:0]   gain_ff, gain_in;
   logic                  seek_pend_ff, seek_pend_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   logic [KIND_W-1:0]     kind_ff;
   logic [MODE_W-1:0]     req_mode_ff;
   logic [TIME_BITS-1:0]  ticks_ff;
   logic                  ended_ff;
   logic [LEVEL_BITS:0]   ramp_ff, ramp_in;
   logic                  gupd_ff, gupd_in;
   action_type            act_ff, act_in;
   logic                  seek_ff, seek_in;
   logic                  ign_ff, ign_in;

   logic [LEVEL_BITS:0]   out_level_ff;
   logic [LEVEL_BITS:0]   out_gain_ff;
   logic                  out_gupd_ff;
   action_type            out_act_ff;
   logic                  out_seek_ff;
   logic                  out_ign_ff;
   phase_type             out_phase_ff;

   logic                  accept;
   logic                  load_out;
   logic [TW-1:0]         ticks_ext;
   logic [TIME_BITS-1:0]  ticks_sat;
   logic                  is_play, is_stop, faded;
   logic                  cur_pause;
   logic                  req_is_play, req_is_pause;
   logic                  cmd_ignore;
   logic [TIME_BITS-1:0]  el_eff;
   logic [LEVEL_BITS:0]   target_lvl;
   logic [LEVEL_BITS:0]   fade_out_lvl;
   logic                  div_start, div_done;
   logic [LEVEL_BITS-1:0] div_quo;
   logic                  sq_start, sq_done;
   logic [LEVEL_BITS-1:0] sq_res;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign load_out  = (state_ff == ST_OUT) && (!rsp_valid_ff || !rsp_stall);

   // saturate the fade length into the timer range
   always_comb begin
      ticks_ext = TW'(req_fade_ticks);
      ticks_sat = (ticks_ext > TW'(TIME_MAX)) ? TIME_MAX : TIME_BITS'(ticks_ext);
   end

   always_comb begin
      is_play      = (mode_ff == MODE_PLAY_NOW) || (mode_ff == MODE_PLAY_FADE);
      is_stop      = (mode_ff == MODE_STOP_NOW) || (mode_ff == MODE_STOP_FADE);
      faded        = mode_ff[0];
      cur_pause    = (mode_ff == MODE_PAUSE_NOW) || (mode_ff == MODE_PAUSE_FADE);
      req_is_play  = (req_mode_ff == MODE_PLAY_NOW) || (req_mode_ff == MODE_PLAY_FADE);
      req_is_pause = (req_mode_ff == MODE_PAUSE_NOW) || (req_mode_ff == MODE_PAUSE_FADE);
      cmd_ignore   = (req_mode_ff > MODE_STOP_FADE)
                  || (req_is_play && is_play && (phase_ff == PH_DONE))
                  || (req_is_pause && cur_pause);
      el_eff       = running_ff ? elapsed_ff : '0;
      fade_out_lvl = LVL_ONE - ramp_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mode_ff      <= MODE_STOP_NOW;
         phase_ff     <= PH_DONE;
         fade_len_ff  <= '0;
         elapsed_ff   <= '0;
         running_ff   <= 1'b0;
         level_ff     <= '0;
         gain_ff      <= '0;
         seek_pend_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         phase_ff     <= phase_in;
         fade_len_ff  <= fade_len_in;
         elapsed_ff   <= elapsed_in;
         running_ff   <= running_in;
         level_ff     <= level_in;
         gain_ff      <= gain_in;
         seek_pend_ff <= seek_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ramp_ff <= ramp_in;
      gupd_ff <= gupd_in;
      act_ff  <= act_in;
      seek_ff <= seek_in;
      ign_ff  <= ign_in;
      if (accept) begin
         kind_ff     <= req_kind;
         req_mode_ff <= req_mode_request;
         ticks_ff    <= ticks_sat;
         ended_ff    <= req_stream_ended;
      end
      if (load_out) begin
         out_level_ff <= level_ff;
         out_gain_ff  <= gain_ff;
         out_gupd_ff  <= gupd_ff;
         out_act_ff   <= act_ff;
         out_seek_ff  <= seek_ff;
         out_ign_ff   <= ign_ff;
         out_phase_ff <= phase_ff;
      end
   end

   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      phase_in     = phase_ff;
      fade_len_in  = fade_len_ff;
      elapsed_in   = elapsed_ff;
      running_in   = running_ff;
      level_in     = level_ff;
      gain_in      = gain_ff;
      seek_pend_in = seek_pend_ff;
      ramp_in      = ramp_ff;
      gupd_in      = gupd_ff;
      act_in       = act_ff;
      seek_in      = seek_ff;
      ign_in       = ign_ff;
      div_start    = 1'b0;
      sq_start     = 1'b0;
      target_lvl   = level_ff;

      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            gupd_in = 1'b0;
            act_in  = ACT_NONE;
            seek_in = 1'b0;
            ign_in  = 1'b0;
            if (kind_ff == KIND_CMD) begin
               if (cmd_ignore) begin
                  ign_in   = 1'b1;
                  state_in = ST_OUT;
               end else begin
                  mode_in     = req_mode_ff;
                  fade_len_in = ticks_ff;
                  phase_in    = PH_READY;
                  running_in  = 1'b0;
                  elapsed_in  = '0;
                  state_in    = ST_LVL;
               end
            end else begin
               if (running_ff && (elapsed_ff < TIME_MAX)) begin
                  elapsed_in = elapsed_ff + 1'b1;
               end
               state_in = ST_LVL;
            end
         end
         ST_LVL: begin
            if (faded) begin
               running_in = 1'b1;
               elapsed_in = el_eff;
               if ((fade_len_ff == '0) || (el_eff >= fade_len_ff)) begin
                  ramp_in  = LVL_ONE;
                  state_in = ST_APPLY;
               end else begin
                  div_start = 1'b1;
                  state_in  = ST_DIV;
               end
            end else begin
               running_in = 1'b0;
               elapsed_in = '0;
               state_in   = ST_APPLY;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               ramp_in  = {1'b0, div_quo};
               state_in = ST_APPLY;
            end
         end
         ST_APPLY: begin
            if (!faded) begin
               target_lvl = is_play ? LVL_ONE : '0;
               gupd_in    = (target_lvl != level_ff);
            end else if (is_play) begin
               target_lvl = ramp_ff;
               gupd_in    = (target_lvl != level_ff);
            end else begin
               target_lvl = fade_out_lvl;
               gupd_in    = (fade_out_lvl < level_ff);
            end

            if (is_play) begin
               if (phase_ff == PH_READY) begin
                  if (seek_pend_ff) begin
                     seek_pend_in = 1'b0;
                     seek_in      = 1'b1;
                  end
                  phase_in = PH_DONE;
                  act_in   = ACT_PLAY;
               end else if ((phase_ff == PH_DONE) && ended_ff) begin
                  phase_in = PH_EOS;
               end
            end else if (!faded) begin
               if (phase_ff == PH_READY) begin
                  phase_in = PH_DONE;
                  act_in   = is_stop ? ACT_STOP : ACT_PAUSE;
               end
            end else begin
               if (phase_ff == PH_READY) begin
                  if (is_stop) begin
                     seek_pend_in = 1'b1;
                  end
                  phase_in = PH_WAIT;
               end else if ((phase_ff == PH_WAIT) && (elapsed_ff >= fade_len_ff)) begin
                  phase_in = PH_DONE;
                  act_in   = is_stop ? ACT_STOP : ACT_PAUSE;
                  if (is_stop) begin
                     seek_pend_in = 1'b0;
                  end
               end
            end

            if (gupd_in) begin
               level_in = target_lvl;
               if (target_lvl == LVL_ONE) begin
                  gain_in  = LVL_ONE;
                  state_in = ST_OUT;
               end else begin
                  sq_start = 1'b1;
                  state_in = ST_SQR;
               end
            end else begin
               state_in = ST_OUT;
            end
         end
         ST_SQR: begin
            if (sq_done) begin
               gain_in  = {1'b0, sq_res};
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (load_out) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   afc_divider #(
      .TIME_BITS  (TIME_BITS),
      .LEVEL_BITS (LEVEL_BITS)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (el_eff),
      .divisor  (fade_len_ff),
      .quotient (div_quo),
      .done     (div_done)
   );

   afc_squarer #(
      .LEVEL_BITS (LEVEL_BITS)
   ) u_squarer (
      .clock   (clock),
      .reset   (reset),
      .start   (sq_start),
      .operand (level_in[LEVEL_BITS-1:0]),
      .result  (sq_res),
      .done    (sq_done)
   );

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_fade_level       = LVL_W'(out_level_ff);
   assign rsp_gain             = GAIN_W'(out_gain_ff);
   assign rsp_gain_update      = out_gupd_ff;
   assign rsp_transport_action = out_act_ff;
   assign rsp_seek_to_start    = out_seek_ff;
   assign rsp_ignored          = out_ign_ff;
   assign rsp_voice_phase      = out_phase_ff;

`ifndef SYNTH
   a_level_range: assert property (@(posedge clock) disable iff (reset)
      level_ff <= LVL_ONE)
      else $error("fade level above full scale");

   a_timer_idle_clear: assert property (@(posedge clock) disable iff (reset)
      !running_ff |-> (elapsed_ff == '0))
      else $error("elapsed count held while timer stopped");

   a_wait_only_faded: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_WAIT) |-> (mode_ff == MODE_PAUSE_FADE || mode_ff == MODE_STOP_FADE))
      else $error("waiting phase outside a faded pause or stop");

   a_ignored_quiet: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ignored) |-> (rsp_transport_action == ACT_NONE
                                     && !rsp_gain_update && !rsp_seek_to_start))
      else $error("dropped command produced an action");

   a_div_ramp_below_one: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV && div_done) |=> (ramp_ff < LVL_ONE))
      else $error("divided ramp reached full scale");
`endif

endmodule

/* rtl/afc_divider.sv */
`timescale 1ns / 1ps
// bit-serial restoring divider for the fade ramp fraction
// one quotient bit per cycle; needs dividend below divisor

module afc_divider #(
   parameter int TIME_BITS  = 24,
   parameter int LEVEL_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [TIME_BITS-1:0]  dividend,
   input  logic [TIME_BITS-1:0]  divisor,
   output logic [LEVEL_BITS-1:0] quotient,
   output logic                  done
);

   localparam int CNT_W = $clog2(LEVEL_BITS);

   logic [TIME_BITS-1:0]  rem_ff, rem_in;
   logic [TIME_BITS-1:0]  dvs_ff;
   logic [LEVEL_BITS-1:0] quo_ff;
   logic [CNT_W-1:0]      cnt_ff;
   logic                  busy_ff;
   logic                  done_ff;
   logic [TIME_BITS:0]    shifted;
   logic [TIME_BITS:0]    diff;
   logic                  qbit;

   always_comb begin
      shifted = {rem_ff, 1'b0};
      diff    = shifted - {1'b0, dvs_ff};
      qbit    = (shifted >= {1'b0, dvs_ff});
      rem_in  = qbit ? diff[TIME_BITS-1:0] : shifted[TIME_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(LEVEL_BITS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= dividend;
         dvs_ff <= divisor;
         quo_ff <= '0;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= {quo_ff[LEVEL_BITS-2:0], qbit};
      end
   end

   assign quotient = quo_ff;
   assign done     = done_ff;

endmodule

/* rtl/afc_squarer.sv */
`timescale 1ns / 1ps
// bit-serial shift-add squarer for the gain curve
// one multiplier bit per cycle, msb first; returns the upper half

module afc_squarer #(
   parameter int LEVEL_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [LEVEL_BITS-1:0] operand,
   output logic [LEVEL_BITS-1:0] result,
   output logic                  done
);

   localparam int CNT_W = $clog2(LEVEL_BITS);

   logic [2*LEVEL_BITS-1:0] acc_ff, acc_in;
   logic [LEVEL_BITS-1:0]   mcand_ff;
   logic [LEVEL_BITS-1:0]   mplr_ff;
   logic [CNT_W-1:0]        cnt_ff;
   logic                    busy_ff;
   logic                    done_ff;

   always_comb begin
      acc_in = {acc_ff[2*LEVEL_BITS-2:0], 1'b0};
      if (mplr_ff[LEVEL_BITS-1]) begin
         acc_in = acc_in + {{LEVEL_BITS{1'b0}}, mcand_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(LEVEL_BITS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         acc_ff   <= '0;
         mcand_ff <= operand;
         mplr_ff  <= operand;
      end else if (busy_ff) begin
         acc_ff  <= acc_in;
         mplr_ff <= {mplr_ff[LEVEL_BITS-2:0], 1'b0};
      end
   end

   assign result = acc_ff[2*LEVEL_BITS-1:LEVEL_BITS];
   assign done   = done_ff;

endmodule
